/* rtl/core/clcd_pkg.sv */
// Package with types, codes and tables for the 4-bit character LCD controller.
package clcd_pkg;

  localparam int DELAY_BITS  = 16;
  localparam int LONG_W      = 16;
  localparam int SHORT_W     = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int FONT_BYTES  = 64;
  localparam int FONT_IDX_W  = $clog2(FONT_BYTES);
  localparam int STEP_W      = 7;
  localparam int IN_DATA_W   = 24;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 16;

  localparam logic [STEP_W-1:0] STEP_FIRST_CMD = 7'd4;
  localparam logic [STEP_W-1:0] STEP_FONT      = 7'd9;
  localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(9 + FONT_BYTES);

  localparam logic [LONG_W-1:0]  LONG_RESET  = 16'd50;
  localparam logic [SHORT_W-1:0] SHORT_RESET = 8'd1;

  localparam logic [7:0] NIB_FUNC_8BIT = 8'h03;
  localparam logic [7:0] NIB_FUNC_4BIT = 8'h02;
  localparam logic [7:0] CMD_HOME_ADDR = 8'h80;

  typedef enum logic {
    REG_LONG_DELAY  = 1'b0,
    REG_SHORT_DELAY = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CMD    = 2'd1,
    OP_DATA   = 2'd2,
    OP_CURSOR = 2'd3
  } op_t;

  typedef enum logic [7:0] {
    PH_POWER = 8'b0000_0001,
    PH_EN_A  = 8'b0000_0010,
    PH_EN_B  = 8'b0000_0100,
    PH_EN_C  = 8'b0000_1000,
    PH_LONG  = 8'b0001_0000,
    PH_POLL  = 8'b0010_0000,
    PH_GAP   = 8'b0100_0000,
    PH_IDLE  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic       rejected;
    logic       init_done;
    logic       ready_res;
    logic       d7_released;
    logic [3:0] data_nibble;
    logic       en_pin;
    logic       rw_pin;
    logic       rs_pin;
  } out_word_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h0C;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      default: b = 8'h40;
    endcase
    return b;
  endfunction

  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'h11, 8'h0A, 8'h04, 8'h1B, 8'h11, 8'h11, 8'h11, 8'h0E,
    8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10,
    8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18,
    8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1C,
    8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1E,
    8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

/* rtl/core/char_lcd_4bit_controller.sv */
// Top level of the tick-driven 4-bit character LCD controller with power-on and font load.
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid / s_tready  tuser op, tdata value, line, column, busy_in
//   m_*      out        m_tvalid / m_tready  tdata pin levels and status
//   wr_*     in         wr_en                wr_index, wr_data
//
// Each input word is one tick and yields one output word; one word per cycle is taken while s_tready is high.
// The whole sequencer step is one pass of logic between the state registers and the
// output register, and a skid register holds a second output word while m_tready is low.
// s_tready drops only when both output registers are full.
// Reset clears the sequencer to the power-on wait and loads the delay registers.
module char_lcd_4bit_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // Fields from bit 0: value[7:0], line[9:8], column[16:10], busy_in[17], zero fill.
  input  logic [clcd_pkg::IN_DATA_W-1:0]     s_tdata,
  // Fields from bit 0: op[1:0].
  input  logic [clcd_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // Fields from bit 0: rs_pin, rw_pin, en_pin, data_nibble[6:3], d7_released,
  // ready_res, init_done, rejected, zero fill.
  output logic [clcd_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               wr_en,
  input  logic                               wr_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]    wr_data
);
  import clcd_pkg::*;

  logic [LONG_W-1:0]     long_delay_ticks;
  logic [SHORT_W-1:0]    short_delay_ticks;

  phase_t                phase, phase_next;
  logic [DELAY_BITS-1:0] delay_count, delay_count_next;
  logic [STEP_W-1:0]     init_step, init_step_next;
  logic [7:0]            byte_hold, byte_hold_next;
  logic                  rs_hold, rs_hold_next;
  logic                  low_half, low_half_next;
  logic                  pin_rs, pin_rs_next;
  logic                  pin_rw, pin_rw_next;
  logic                  pin_en, pin_en_next;
  logic [3:0]            pin_nib, pin_nib_next;
  logic                  ready_flag, ready_flag_next;
  logic                  done_flag, done_flag_next;

  logic                  skid_valid;
  out_word_t             skid_word;
  out_word_t             out_word;
  out_word_t             new_word;

  op_t                   op;
  logic [7:0]            in_value;
  logic [1:0]            in_line;
  logic [6:0]            in_column;
  logic                  in_busy;
  logic [6:0]            cursor_addr;

  logic                  accepted;
  logic                  rejected;
  logic                  start_item;
  logic                  begin_b;
  logic                  begin_rs;
  logic [7:0]            begin_val;
  logic                  start_nib;
  logic                  start_poll;
  logic [STEP_W-1:0]     font_off;
  logic [STEP_W-1:0]     cmd_off;

  logic                  in_acc;
  logic                  out_pop;

  assign op        = op_t'(s_tuser[1:0]);
  assign in_value  = s_tdata[7:0];
  assign in_line   = s_tdata[9:8];
  assign in_column = s_tdata[16:10];
  assign in_busy   = s_tdata[17];

  assign cursor_addr = 7'({in_line - 2'd1, 6'd0}) + (in_column - 7'd1);

  always_comb begin
    phase_next       = phase;
    delay_count_next = delay_count;
    init_step_next   = init_step;
    byte_hold_next   = byte_hold;
    rs_hold_next     = rs_hold;
    low_half_next    = low_half;
    pin_rs_next      = pin_rs;
    pin_rw_next      = pin_rw;
    pin_en_next      = pin_en;
    pin_nib_next     = pin_nib;
    ready_flag_next  = ready_flag;
    done_flag_next   = done_flag;
    accepted         = 1'b0;
    rejected         = 1'b0;
    start_item       = 1'b0;
    begin_b          = 1'b0;
    begin_rs         = 1'b0;
    begin_val        = 8'd0;
    start_nib        = 1'b0;
    start_poll       = 1'b0;

    if (op != OP_TICK) begin
      if (ready_flag && phase == PH_IDLE) begin
        accepted        = 1'b1;
        ready_flag_next = 1'b0;
        begin_b         = 1'b1;
        case (op)
          OP_CMD: begin
            begin_val = in_value;
            begin_rs  = 1'b0;
          end
          OP_DATA: begin
            begin_val = in_value;
            begin_rs  = 1'b1;
          end
          default: begin
            begin_val = CMD_HOME_ADDR + {1'b0, cursor_addr};
            begin_rs  = 1'b0;
          end
        endcase
      end else begin
        rejected = 1'b1;
      end
    end

    if (!accepted && phase != PH_IDLE) begin
      if (delay_count > DELAY_BITS'(1)) begin
        delay_count_next = delay_count - DELAY_BITS'(1);
      end else begin
        case (phase)
          PH_POWER: begin
            init_step_next = '0;
            start_item     = 1'b1;
          end
          PH_EN_A: begin
            pin_rw_next      = 1'b0;
            pin_en_next      = 1'b1;
            phase_next       = PH_EN_B;
            delay_count_next = DELAY_BITS'(short_delay_ticks);
          end
          PH_EN_B: begin
            pin_rw_next      = 1'b0;
            pin_en_next      = 1'b0;
            phase_next       = PH_EN_C;
            delay_count_next = DELAY_BITS'(short_delay_ticks);
          end
          PH_EN_C: begin
            if (!low_half) begin
              low_half_next = 1'b1;
              start_nib     = 1'b1;
            end else if (!done_flag && init_step <= STEP_W'(1)) begin
              phase_next       = PH_LONG;
              delay_count_next = DELAY_BITS'(long_delay_ticks);
            end else begin
              start_poll = 1'b1;
            end
          end
          PH_LONG: begin
            init_step_next = init_step + STEP_W'(1);
            start_item     = 1'b1;
          end
          PH_POLL: begin
            pin_rs_next = 1'b0;
            pin_rw_next = 1'b0;
            pin_en_next = 1'b0;
            if (in_busy) begin
              phase_next       = PH_GAP;
              delay_count_next = DELAY_BITS'(1);
            end else begin
              phase_next = PH_IDLE;
              if (done_flag) begin
                ready_flag_next = 1'b1;
              end else if (init_step >= STEP_LAST) begin
                done_flag_next  = 1'b1;
                ready_flag_next = 1'b1;
              end else begin
                init_step_next = init_step + STEP_W'(1);
                start_item     = 1'b1;
              end
            end
          end
          PH_GAP: begin
            start_poll = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end

    if (start_poll) begin
      pin_rs_next      = 1'b0;
      pin_rw_next      = 1'b1;
      pin_en_next      = 1'b1;
      phase_next       = PH_POLL;
      delay_count_next = DELAY_BITS'(short_delay_ticks);
    end

    font_off = init_step_next - STEP_FONT;
    cmd_off  = init_step_next - STEP_FIRST_CMD;

    if (start_item) begin
      if (init_step_next < STEP_FIRST_CMD) begin
        byte_hold_next = (init_step_next < STEP_W'(3)) ? NIB_FUNC_8BIT : NIB_FUNC_4BIT;
        rs_hold_next   = 1'b0;
        low_half_next  = 1'b1;
        start_nib      = 1'b1;
      end else if (init_step_next < STEP_FONT) begin
        begin_b   = 1'b1;
        begin_val = init_cmd(cmd_off[2:0]);
        begin_rs  = 1'b0;
      end else if (init_step_next < STEP_LAST) begin
        begin_b   = 1'b1;
        begin_val = FONT_ROM[font_off[FONT_IDX_W-1:0]];
        begin_rs  = 1'b1;
      end else begin
        begin_b   = 1'b1;
        begin_val = CMD_HOME_ADDR;
        begin_rs  = 1'b0;
      end
    end

    if (begin_b) begin
      byte_hold_next = begin_val;
      rs_hold_next   = begin_rs;
      low_half_next  = 1'b0;
      start_nib      = 1'b1;
    end

    if (start_nib) begin
      pin_rs_next      = rs_hold_next;
      pin_rw_next      = 1'b0;
      pin_en_next      = 1'b0;
      pin_nib_next     = low_half_next ? byte_hold_next[3:0] : byte_hold_next[7:4];
      phase_next       = PH_EN_A;
      delay_count_next = DELAY_BITS'(short_delay_ticks);
    end
  end

  always_comb begin
    new_word.rs_pin      = pin_rs_next;
    new_word.rw_pin      = pin_rw_next;
    new_word.en_pin      = pin_en_next;
    new_word.data_nibble = pin_nib_next;
    new_word.d7_released = (phase_next == PH_POLL);
    new_word.ready_res   = ready_flag_next;
    new_word.init_done   = done_flag_next;
    new_word.rejected    = rejected;
  end

  assign s_tready = !skid_valid;
  assign in_acc   = s_tvalid && s_tready;
  assign out_pop  = m_tvalid && m_tready;
  assign m_tdata  = OUT_DATA_W'(out_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      long_delay_ticks  <= LONG_RESET;
      short_delay_ticks <= SHORT_RESET;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_LONG_DELAY:  long_delay_ticks  <= wr_data[LONG_W-1:0];
        REG_SHORT_DELAY: short_delay_ticks <= wr_data[SHORT_W-1:0];
        default:         long_delay_ticks  <= long_delay_ticks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_POWER;
      delay_count <= DELAY_BITS'(LONG_RESET);
      init_step   <= '0;
      byte_hold   <= '0;
      rs_hold     <= 1'b0;
      low_half    <= 1'b0;
      pin_rs      <= 1'b0;
      pin_rw      <= 1'b0;
      pin_en      <= 1'b0;
      pin_nib     <= '0;
      ready_flag  <= 1'b0;
      done_flag   <= 1'b0;
    end else if (in_acc) begin
      phase       <= phase_next;
      delay_count <= delay_count_next;
      init_step   <= init_step_next;
      byte_hold   <= byte_hold_next;
      rs_hold     <= rs_hold_next;
      low_half    <= low_half_next;
      pin_rs      <= pin_rs_next;
      pin_rw      <= pin_rw_next;
      pin_en      <= pin_en_next;
      pin_nib     <= pin_nib_next;
      ready_flag  <= ready_flag_next;
      done_flag   <= done_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!in_acc) begin
          m_tvalid <= 1'b0;
        end
      end
      if (in_acc) begin
        if (!m_tvalid || out_pop) begin
          m_tvalid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop && skid_valid) begin
      out_word <= skid_word;
    end else if (in_acc && (!m_tvalid || out_pop)) begin
      out_word <= new_word;
    end
    if (in_acc && m_tvalid && !out_pop) begin
      skid_word <= new_word;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register holds a word while the output register is empty");

  a_ready_implies_done: assert property (@(posedge clk) disable iff (rst)
    ready_flag |-> done_flag)
    else $error("controller reports ready before initialization finished");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag)
    else $error("init done flag fell without reset");

  a_request_clears_ready: assert property (@(posedge clk) disable iff (rst)
    (in_acc && op != OP_TICK && ready_flag && phase == PH_IDLE) |=>
      (!ready_flag && phase == PH_EN_A))
    else $error("accepted request did not start a byte");

endmodule

/* tb/char_lcd_4bit_controller_tb.sv */
// Self-checking testbench for the 4-bit character LCD controller: tick prediction and pin checks.
module char_lcd_4bit_controller_tb;
  import clcd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 400;

  typedef struct {
    op_t        op;
    logic [7:0] value;
    logic [1:0] line;
    logic [6:0] col;
    logic       busy;
  } tick_item_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  wr_en;
  logic                  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  logic hold_rx;
  logic steady_tx;
  int   sent_n;

  class pin_scoreboard;
    logic [15:0] long_ticks;
    logic [7:0]  short_ticks;
    phase_t      ph;
    logic [15:0] cnt;
    logic [6:0]  step;
    logic [7:0]  hold_byte;
    logic        hold_rs;
    logic        lo_half;
    logic [6:0]  pins;
    logic        rdy;
    logic        done;
    out_word_t   pin_words_due[$];
    int          errors;
    int          n_taken;
    int          n_rejected;
    int          n_busy;

    function new();
      long_ticks = 16'd50;
      short_ticks = 8'd1;
      step = '0;
      hold_byte = '0;
      hold_rs = 1'b0;
      lo_half = 1'b0;
      pins = '0;
      rdy = 1'b0;
      done = 1'b0;
      errors = 0;
      n_taken = 0;
      n_rejected = 0;
      n_busy = 0;
      go(PH_POWER, long_ticks);
    endfunction

    function void set_reg(reg_index_t idx, logic [15:0] v);
      if (idx == REG_LONG_DELAY) long_ticks = v;
      else short_ticks = v[7:0];
    endfunction

    function void drive_pins(logic rs, logic rw, logic en, logic [3:0] nib);
      pins = {nib, en, rw, rs};
    endfunction

    function void go(phase_t p, logic [15:0] ticks);
      ph = p;
      cnt = ticks;
    endfunction

    function void nibble_start();
      drive_pins(hold_rs, 1'b0, 1'b0, lo_half ? hold_byte[3:0] : hold_byte[7:4]);
      go(PH_EN_A, 16'(short_ticks));
    endfunction

    function void load_byte(logic [7:0] b, logic rs);
      hold_byte = b;
      hold_rs = rs;
      lo_half = 1'b0;
      nibble_start();
    endfunction

    function logic [7:0] setup_cmd(logic [6:0] i);
      case (i)
        7'd0:    return 8'h28;
        7'd1:    return 8'h0C;
        7'd2:    return 8'h01;
        7'd3:    return 8'h06;
        default: return 8'h40;
      endcase
    endfunction

    function logic [7:0] font_byte(logic [5:0] i);
      case (i[5:3])
        3'd0: begin
          case (i[2:0])
            3'd1:    return 8'h0A;
            3'd2:    return 8'h04;
            3'd3:    return 8'h1B;
            3'd7:    return 8'h0E;
            default: return 8'h11;
          endcase
        end
        3'd1:    return 8'h10;
        3'd2:    return 8'h18;
        3'd3:    return 8'h1C;
        3'd4:    return 8'h1E;
        3'd5:    return 8'h1F;
        default: return 8'h00;
      endcase
    endfunction

    function void next_item();
      logic [6:0] rel;
      if (step < 4) begin
        hold_byte = (step < 3) ? 8'h03 : 8'h02;
        hold_rs = 1'b0;
        lo_half = 1'b1;
        nibble_start();
      end else if (step < 9) begin
        load_byte(setup_cmd(step - 7'd4), 1'b0);
      end else if (step < 9 + 64) begin
        rel = step - 7'd9;
        load_byte(font_byte(rel[5:0]), 1'b1);
      end else begin
        load_byte(8'h80, 1'b0);
      end
    endfunction

    function void poll_start();
      drive_pins(1'b0, 1'b1, 1'b1, pins[6:3]);
      go(PH_POLL, 16'(short_ticks));
    endfunction

    function void poll_done();
      ph = PH_IDLE;
      if (done) begin
        rdy = 1'b1;
      end else if (step >= 9 + 64) begin
        done = 1'b1;
        rdy = 1'b1;
      end else begin
        step = step + 7'd1;
        next_item();
      end
    endfunction

    function void finish_phase(logic busy);
      logic [3:0] nib;
      logic       rs;
      nib = pins[6:3];
      rs = pins[0];
      case (ph)
        PH_POWER: begin
          step = '0;
          next_item();
        end
        PH_EN_A: begin
          drive_pins(rs, 1'b0, 1'b1, nib);
          go(PH_EN_B, 16'(short_ticks));
        end
        PH_EN_B: begin
          drive_pins(rs, 1'b0, 1'b0, nib);
          go(PH_EN_C, 16'(short_ticks));
        end
        PH_EN_C: begin
          if (!lo_half) begin
            lo_half = 1'b1;
            nibble_start();
          end else if (!done && step <= 1) begin
            go(PH_LONG, long_ticks);
          end else begin
            poll_start();
          end
        end
        PH_LONG: begin
          step = step + 7'd1;
          next_item();
        end
        PH_POLL: begin
          drive_pins(1'b0, 1'b0, 1'b0, nib);
          if (busy) begin
            n_busy++;
            go(PH_GAP, 16'd1);
          end else begin
            poll_done();
          end
        end
        PH_GAP: poll_start();
        default: ph = PH_IDLE;
      endcase
    endfunction

    function logic ready_for_request();
      return rdy && ph == PH_IDLE;
    endfunction

    function int pending();
      return pin_words_due.size();
    endfunction

    // Advances the sequencer by one accepted word and queues the pin levels it must show.
    function void take_word(tick_item_t it);
      out_word_t  w;
      logic       taken;
      logic       rej;
      logic [6:0] addr;
      taken = 1'b0;
      rej = 1'b0;
      if (it.op != OP_TICK) begin
        if (rdy && ph == PH_IDLE) begin
          rdy = 1'b0;
          taken = 1'b1;
          n_taken++;
          case (it.op)
            OP_CMD:  load_byte(it.value, 1'b0);
            OP_DATA: load_byte(it.value, 1'b1);
            default: begin
              addr = 7'((int'(it.line) - 1) * 64 + int'(it.col) - 1);
              load_byte({1'b1, addr}, 1'b0);
            end
          endcase
        end else begin
          rej = 1'b1;
          n_rejected++;
        end
      end
      if (!taken && ph != PH_IDLE) begin
        if (cnt > 1) cnt = cnt - 16'd1;
        else finish_phase(it.busy);
      end
      w.rs_pin = pins[0];
      w.rw_pin = pins[1];
      w.en_pin = pins[2];
      w.data_nibble = pins[6:3];
      w.d7_released = (ph == PH_POLL);
      w.ready_res = rdy;
      w.init_done = done;
      w.rejected = rej;
      pin_words_due.push_back(w);
    endfunction

    function void match_pins(logic [OUT_DATA_W-1:0] got);
      out_word_t w;
      out_word_t a;
      if (pin_words_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected output word %h", got);
        return;
      end
      w = pin_words_due.pop_front();
      a = out_word_t'(got[10:0]);
      if (a.rs_pin !== w.rs_pin || a.rw_pin !== w.rw_pin || a.en_pin !== w.en_pin ||
          a.data_nibble !== w.data_nibble || a.d7_released !== w.d7_released ||
          a.ready_res !== w.ready_res || a.init_done !== w.init_done ||
          a.rejected !== w.rejected || got[OUT_DATA_W-1:11] !== '0) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: expected rs=%b rw=%b en=%b nib=%h rel=%b rdy=%b done=%b rej=%b",
                   w.rs_pin, w.rw_pin, w.en_pin, w.data_nibble, w.d7_released,
                   w.ready_res, w.init_done, w.rejected);
          $display("            got rs=%b rw=%b en=%b nib=%h rel=%b rdy=%b done=%b rej=%b fill=%h",
                   a.rs_pin, a.rw_pin, a.en_pin, a.data_nibble, a.d7_released,
                   a.ready_res, a.init_done, a.rejected, got[OUT_DATA_W-1:11]);
        end
      end
    endfunction
  endclass

  pin_scoreboard sb = new();

  char_lcd_4bit_controller uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.match_pins(m_tdata);
  end

  // Output side: random stalls, steady stretches, and one long hold-off on request.
  initial begin
    int   gap;
    int   got_n;
    logic steady_rx;
    logic hold_served;
    m_tready = 1'b0;
    got_n = 0;
    steady_rx = 1'b0;
    hold_served = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rx && !hold_served) begin
        gap = 80;
        hold_served = 1'b1;
      end else begin
        gap = steady_rx ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got_n++;
      if (got_n % 64 == 0) steady_rx = ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
  end

  function automatic tick_item_t rand_item(int busy_pct);
    tick_item_t it;
    it.op = OP_TICK;
    it.value = 8'($urandom_range(0, 255));
    it.line = 2'($urandom_range(0, 3));
    it.col = 7'($urandom_range(0, 127));
    it.busy = ($urandom_range(0, 99) < busy_pct);
    return it;
  endfunction

  task automatic send_word(tick_item_t it);
    int gap;
    gap = steady_tx ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, it.busy, it.col, it.line, it.value};
    s_tuser <= it.op;
    do @(posedge clk); while (!s_tready);
    sb.take_word(it);
    sent_n++;
    if (sent_n % 64 == 0) steady_tx = ($urandom_range(0, 3) == 0);
    @(negedge clk);
  endtask

  task automatic request(op_t op, logic [7:0] v, logic [1:0] ln, logic [6:0] col);
    tick_item_t it;
    it = rand_item(30);
    it.op = op;
    it.value = v;
    it.line = ln;
    it.col = col;
    send_word(it);
  endtask

  task automatic tick_until_ready(int busy_pct, int reject_pct);
    tick_item_t it;
    while (!sb.ready_for_request()) begin
      it = rand_item(busy_pct);
      if ($urandom_range(0, 99) < reject_pct) it.op = op_t'($urandom_range(1, 3));
      send_word(it);
    end
  endtask

  task automatic run_random(int goal, int busy_pct);
    tick_item_t it;
    logic       rdy_now;
    int         n;
    n = 0;
    while (n < goal) begin
      rdy_now = sb.ready_for_request();
      it = rand_item(busy_pct);
      if (rdy_now) begin
        if ($urandom_range(0, 9) != 0) it.op = op_t'($urandom_range(1, 3));
      end else if ($urandom_range(0, 99) < 6) begin
        it.op = op_t'($urandom_range(1, 3));
      end
      send_word(it);
      if (!(rdy_now && it.op == OP_TICK)) n++;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] v);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [1:0] cur_line [6];
    logic [6:0] cur_col [6];
    cur_line = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd1, 2'd2};
    cur_col = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd127, 7'd0};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_TICK;
    wr_en = 1'b0;
    wr_index = REG_LONG_DELAY;
    wr_data = '0;
    hold_rx = 1'b0;
    steady_tx = 1'b0;
    sent_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A zero long delay still waits one tick after each of the first two nibbles.
    write_reg(REG_LONG_DELAY, 16'd0);
    write_reg(REG_SHORT_DELAY, 16'd1);

    // Power-on and font load with requests thrown in that must be rejected, then command, data and cursor requests.
    tick_until_ready(30, 4);
    request(OP_TICK, 8'h00, 2'd0, 7'd0);
    request(OP_CMD, 8'h00, 2'd0, 7'd0);
    tick_until_ready(30, 0);
    request(OP_CMD, 8'hFF, 2'd3, 7'd127);
    request(OP_DATA, 8'h33, 2'd0, 7'd0);
    tick_until_ready(30, 0);
    request(OP_DATA, 8'h00, 2'd0, 7'd0);
    tick_until_ready(30, 0);
    request(OP_DATA, 8'hFF, 2'd0, 7'd0);
    tick_until_ready(30, 0);
    request(OP_DATA, 8'hA5, 2'd0, 7'd0);
    tick_until_ready(30, 0);
    for (int k = 0; k < 6; k++) begin
      request(OP_CURSOR, 8'h00, cur_line[k], cur_col[k]);
      tick_until_ready(30, 0);
    end
    drain();

    write_reg(REG_SHORT_DELAY, 16'd2);
    write_reg(REG_LONG_DELAY, 16'hFFFF);
    run_random(RANDOM_WORDS * 3 / 10, 25);
    drain();

    write_reg(REG_SHORT_DELAY, 16'd1);
    write_reg(REG_LONG_DELAY, 16'd0);
    hold_rx = 1'b1;
    run_random(RANDOM_WORDS * 2 / 10, 25);
    drain();
    run_random(RANDOM_WORDS * 2 / 10, 40);
    drain();

    write_reg(REG_SHORT_DELAY, 16'($urandom_range(3, 6)));
    write_reg(REG_LONG_DELAY, 16'd1234);
    run_random(RANDOM_WORDS * 3 / 10, 20);
    drain();

    // Slow enable timing: a single byte with one rejected request during it.
    write_reg(REG_SHORT_DELAY, 16'd32);
    request(OP_DATA, 8'h5A, 2'd1, 7'd1);
    repeat (60) request(OP_TICK, 8'h00, 2'd0, 7'd0);
    request(OP_CMD, 8'h01, 2'd0, 7'd0);
    tick_until_ready(5, 0);
    drain();
    repeat (8) @(posedge clk);

    $display("Covered power-on, font load and %0d words: %0d requests accepted, %0d rejected,",
             sent_n, sb.n_taken, sb.n_rejected);
    $display("%0d busy poll answers, enable phases of 1 to 32 ticks and a long output stall.",
             sb.n_busy);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* char_lcd_4bit_controller.f */
rtl/core/clcd_pkg.sv
rtl/core/char_lcd_4bit_controller.sv
tb/char_lcd_4bit_controller_tb.sv
